/* rtl/mi_pkg.sv */
// Shared definitions for the modular inverse block: word sizes, sequencer
// states and the request/response structs of the shared divider.
// No dependencies; compile first.
package mi_pkg;

  localparam int WORD_BITS = 32;
  localparam int COEF_BITS = WORD_BITS + 1;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETUP  = 5'b00010,
    S_TEST   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
    logic [COEF_BITS-1:0] multiplicand;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [WORD_BITS-1:0] remainder;
    logic [COEF_BITS-1:0] product;
  } div_rsp_t;

endpackage

/* rtl/mi_in_if.sv */
// Input channel of the modular inverse block: valid/ready plus operands.
// Depends on mi_pkg for the word width.
interface mi_in_if;
  logic                         valid;
  logic                         ready;
  logic [mi_pkg::WORD_BITS-1:0] value;
  logic [mi_pkg::WORD_BITS-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink (input valid, input value, input modulus, output ready);
endinterface

/* rtl/mi_out_if.sv */
// Result channel of the modular inverse block: valid/ready plus result.
// Depends on mi_pkg for the word width.
interface mi_out_if;
  logic                         valid;
  logic                         ready;
  logic [mi_pkg::WORD_BITS-1:0] inverse;
  logic                         no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

/* rtl/mi_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle, that also
// accumulates quotient times a multiplicand (mod 2^COEF_BITS). Uses mi_pkg.
module mi_divider (
  input  logic             clk,
  input  logic             rst,
  input  mi_pkg::div_req_t req,
  output mi_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [mi_pkg::CNT_BITS-1:0]  count;
  logic [mi_pkg::WORD_BITS-1:0] rem;
  logic [mi_pkg::WORD_BITS-1:0] quo;
  logic [mi_pkg::WORD_BITS-1:0] divisor;
  logic [mi_pkg::COEF_BITS-1:0] mcand;
  logic [mi_pkg::COEF_BITS-1:0] acc;

  logic [mi_pkg::WORD_BITS:0]   trial;
  logic [mi_pkg::WORD_BITS:0]   diff;
  logic                         ge;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[mi_pkg::WORD_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Pulse done for one cycle after the last quotient bit
      done <= busy && !req.start && (count == mi_pkg::CNT_BITS'(1));
      if (req.start) begin
        busy    <= 1'b1;
        count   <= mi_pkg::CNT_BITS'(mi_pkg::WORD_BITS);
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
        mcand   <= req.multiplicand;
        acc     <= '0;
      end else if (busy) begin
        rem   <= ge ? diff[mi_pkg::WORD_BITS-1:0] : trial[mi_pkg::WORD_BITS-1:0];
        quo   <= {quo[mi_pkg::WORD_BITS-2:0], ge};
        acc   <= {acc[mi_pkg::COEF_BITS-2:0], 1'b0} + (ge ? mcand : '0);
        count <= count - mi_pkg::CNT_BITS'(1);
        if (count == mi_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.remainder = rem;
  assign rsp.product   = acc;

endmodule

/* rtl/modular_inverse.sv */
// Modular inverse by the iterative extended Euclidean algorithm. Each
// transfer on req carries a value and a modulus; one transfer on rsp later
// returns value^-1 mod modulus, or no_inverse = 1 with inverse = 0 when the
// gcd is not one or the modulus is zero (a modulus of one returns one). The
// block takes one item at a time: req.ready is high only while the
// sequencer is idle. Each item runs one division per Euclid step (at
// most about 46 steps for 32-bit operands) on the bit-serial divider,
// which yields one quotient bit per cycle and also forms quotient *
// coefficient alongside. A finished result sits in the rsp output
// register, so the next item is accepted while it waits.
// Depends on mi_pkg, mi_in_if, mi_out_if and mi_divider.
module modular_inverse (
  input  logic      clk,
  input  logic      rst,
  mi_in_if.sink     req,
  mi_out_if.source  rsp
);

  localparam int W = mi_pkg::WORD_BITS;
  localparam int C = mi_pkg::COEF_BITS;

  mi_pkg::state_t   state;
  mi_pkg::div_req_t div_req;
  mi_pkg::div_rsp_t div_rsp;

  // Euclid working set: remainder pair and signed Bezout coefficients
  logic [W-1:0] rem_high;
  logic [W-1:0] rem_low;
  logic [C-1:0] coef_prev;
  logic [C-1:0] coef_curr;
  logic [W-1:0] saved_modulus;

  // Result staged until the output register frees up
  logic [W-1:0] res_inverse;
  logic         res_fail;

  // Output register
  logic         out_valid;
  logic [W-1:0] out_inverse;
  logic         out_no_inverse;
  logic         load_out;

  logic [W-1:0] final_inv;
  logic         high_done;

  // Stepping ends once the high remainder is zero or one
  assign high_done = rem_high < W'(2);

  // Fold a negative coefficient back into [0, modulus)
  assign final_inv = coef_curr[C-1] ? (coef_curr[W-1:0] + saved_modulus)
                                    : coef_curr[W-1:0];

  // Move the staged result out once the output register is free
  assign load_out = (state == mi_pkg::S_FINISH) && (!out_valid || rsp.ready);

  // Launch one division per Euclid step
  always_comb begin
    div_req.start        = (state == mi_pkg::S_TEST) && !high_done && (rem_low != '0);
    div_req.dividend     = rem_high;
    div_req.divisor      = rem_low;
    div_req.multiplicand = coef_prev;
  end

  mi_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mi_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once the sink takes it
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        mi_pkg::S_IDLE: begin
          if (req.valid) begin
            rem_high      <= req.value;
            rem_low       <= req.modulus;
            saved_modulus <= req.modulus;
            coef_prev     <= '0;
            coef_curr     <= C'(1);
            state         <= mi_pkg::S_SETUP;
          end
        end
        mi_pkg::S_SETUP: begin
          // Screen the trivial moduli and a zero value up front
          if (saved_modulus == W'(1)) begin
            res_inverse <= W'(1);
            res_fail    <= 1'b0;
            state       <= mi_pkg::S_FINISH;
          end else if (saved_modulus == '0 || rem_high == '0) begin
            res_inverse <= '0;
            res_fail    <= 1'b1;
            state       <= mi_pkg::S_FINISH;
          end else begin
            state <= mi_pkg::S_TEST;
          end
        end
        mi_pkg::S_TEST: begin
          if (high_done) begin
            res_inverse <= final_inv;
            res_fail    <= 1'b0;
            state       <= mi_pkg::S_FINISH;
          end else if (rem_low == '0) begin
            // gcd above one: low remainder ran out first
            res_inverse <= '0;
            res_fail    <= 1'b1;
            state       <= mi_pkg::S_FINISH;
          end else begin
            state <= mi_pkg::S_DIV;
          end
        end
        mi_pkg::S_DIV: begin
          // Advance the remainder and coefficient pairs by one step
          if (div_rsp.done) begin
            rem_high  <= rem_low;
            rem_low   <= div_rsp.remainder;
            coef_prev <= coef_curr - div_rsp.product;
            coef_curr <= coef_prev;
            state     <= mi_pkg::S_TEST;
          end
        end
        mi_pkg::S_FINISH: begin
          // Hold until the output register is free
          if (load_out) begin
            out_inverse    <= res_inverse;
            out_no_inverse <= res_fail;
            state          <= mi_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mi_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == mi_pkg::S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.inverse    = out_inverse;
  assign rsp.no_inverse = out_no_inverse;

`ifndef SYNTHESIS
  // A new item never lands while the divider is still iterating
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  // The divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == mi_pkg::S_DIV))
    else $error("divider done outside divide state");

  // Every division launch moves the sequencer into the divide state with the divider busy
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == mi_pkg::S_DIV) && div_rsp.busy)
    else $error("division launched without entering divide state");

  // A flagged result carries a zero inverse
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.no_inverse) |-> (rsp.inverse == '0))
    else $error("flagged result with nonzero inverse");
`endif

endmodule
